// ===== hdl/cc2d_pkg.sv =====
// Package for the circular convolution scatter engine: shared types, codes and constants.
// Used by all modules in hdl; depends on nothing.
`timescale 1ns / 1ps
package cc2d_pkg;
   localparam int MAX_IMAGE_DIM_DEF  = 64;
   localparam int MAX_FILTER_DIM_DEF = 8;

   typedef enum logic [1:0] {
      KIND_TAP   = 2'd0,
      KIND_IMP   = 2'd1,
      KIND_READ  = 2'd2,
      KIND_CLEAR = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      REG_IMAGE_ROWS  = 3'd0,
      REG_IMAGE_COLS  = 3'd1,
      REG_FILTER_ROWS = 3'd2,
      REG_FILTER_COLS = 3'd3,
      REG_EDGE_MODE   = 3'd4
   } reg_index_type;

   // One classified word handed from the front part to the back part.
   typedef struct packed {
      kind_type    kind;
      logic        in_image;
      logic [5:0]  row;
      logic [5:0]  col;
      logic [15:0] value;
   } cmd_type;
endpackage

// ===== hdl/circular_conv2d_scatter.sv =====
// Top level of the circular convolution scatter engine: configuration registers and glue.
// Depends on cc2d_pkg, cc2d_front and cc2d_back.
`timescale 1ns / 1ps
// Each request word yields one response word, in order. A tap write, a read or an
// impulse outside the image goes from idle straight to the output state, which puts
// its response into the output register. An impulse visits every filter tap in turn
// through one read-multiply-write path of the accumulator memory, in read, multiply
// and write-back steps (read and write-back only for a tap whose position is dropped).
// A clear, and the clearing pass after reset, sweep the accumulator memory one entry
// a cycle, during which no request reaches the back part. A two-word queue lets
// requests arrive meanwhile, and an output register lets the next word start while a
// response waits.
module circular_conv2d_scatter #(
   parameter int MAX_IMAGE_DIM  = cc2d_pkg::MAX_IMAGE_DIM_DEF,
   parameter int MAX_FILTER_DIM = cc2d_pkg::MAX_FILTER_DIM_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // row[5:0], col[11:6], value[27:12]
   input  logic [1:0]  req_tuser,   // kind[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // read_value[31:0], overflow[32]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [6:0]  csr_data
);
   logic [6:0] image_rows_ff, image_cols_ff;
   logic [3:0] filter_rows_ff, filter_cols_ff;
   logic       edge_mode_ff;
   logic       cmd_valid, cmd_ready;
   cc2d_pkg::cmd_type cmd;

   assign csr_ready = 1'b1;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         image_rows_ff  <= 7'd64;
         image_cols_ff  <= 7'd64;
         filter_rows_ff <= 4'd3;
         filter_cols_ff <= 4'd3;
         edge_mode_ff   <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_index)
            cc2d_pkg::REG_IMAGE_ROWS:  image_rows_ff  <= csr_data;
            cc2d_pkg::REG_IMAGE_COLS:  image_cols_ff  <= csr_data;
            cc2d_pkg::REG_FILTER_ROWS: filter_rows_ff <= csr_data[3:0];
            cc2d_pkg::REG_FILTER_COLS: filter_cols_ff <= csr_data[3:0];
            cc2d_pkg::REG_EDGE_MODE:   edge_mode_ff   <= csr_data[0];
            default: ;
         endcase
      end
   end

   cc2d_front #(.MAX_IMAGE_DIM(MAX_IMAGE_DIM)) u_front (
      .clock, .reset, .req_tvalid, .req_tready,
      .req_tdata(req_tdata[27:0]), .req_tuser,
      .image_rows(image_rows_ff), .image_cols(image_cols_ff),
      .cmd_valid, .cmd_ready, .cmd
   );

   cc2d_back #(.MAX_IMAGE_DIM(MAX_IMAGE_DIM), .MAX_FILTER_DIM(MAX_FILTER_DIM)) u_back (
      .clock, .reset, .cmd_valid, .cmd_ready, .cmd,
      .image_rows(image_rows_ff), .image_cols(image_cols_ff),
      .filter_rows(filter_rows_ff), .filter_cols(filter_cols_ff),
      .edge_mode(edge_mode_ff),
      .rsp_tvalid, .rsp_tready, .rsp_tdata
   );
endmodule

// ===== hdl/cc2d_front.sv =====
// Front part: accepts request words, classifies them and queues them for the back part.
// Depends on cc2d_pkg.
`timescale 1ns / 1ps
module cc2d_front #(
   parameter int MAX_IMAGE_DIM = cc2d_pkg::MAX_IMAGE_DIM_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [27:0]       req_tdata,
   input  logic [1:0]        req_tuser,
   input  logic [6:0]        image_rows,
   input  logic [6:0]        image_cols,
   output logic              cmd_valid,
   input  logic              cmd_ready,
   output cc2d_pkg::cmd_type cmd
);
   localparam int DIM_W = $clog2(MAX_IMAGE_DIM + 1);

   cc2d_pkg::cmd_type q_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       wr_ptr_ff, rd_ptr_ff;
   cc2d_pkg::cmd_type cls;
   logic [DIM_W-1:0] ir, ic;
   logic push, pop;

   // Clamp image size the same way the back part clamps it.
   always_comb begin
      ir = (image_rows == 7'd0) ? DIM_W'(1) :
           ({25'd0, image_rows} > 32'(MAX_IMAGE_DIM)) ? DIM_W'(MAX_IMAGE_DIM) :
           DIM_W'(image_rows);
      ic = (image_cols == 7'd0) ? DIM_W'(1) :
           ({25'd0, image_cols} > 32'(MAX_IMAGE_DIM)) ? DIM_W'(MAX_IMAGE_DIM) :
           DIM_W'(image_cols);
   end

   // Classify the incoming word.
   always_comb begin
      cls.kind     = cc2d_pkg::kind_type'(req_tuser);
      cls.row      = req_tdata[5:0];
      cls.col      = req_tdata[11:6];
      cls.value    = req_tdata[27:12];
      cls.in_image = (32'(cls.row) < 32'(ir)) && (32'(cls.col) < 32'(ic));
   end

   assign req_tready = (cnt_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign cmd_valid  = (cnt_ff != 2'd0);
   assign pop        = cmd_valid && cmd_ready;
   assign cmd        = q_ff[rd_ptr_ff];
   assign cnt_in     = cnt_ff + {1'b0, push} - {1'b0, pop};

   // Two-entry queue between the front and the back.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop) rd_ptr_ff <= ~rd_ptr_ff;
      end
      if (push) q_ff[wr_ptr_ff] <= cls;
   end
endmodule

// ===== hdl/cc2d_back.sv =====
// Back part: tap store, accumulator memory and the impulse sequencer.
// Depends on cc2d_pkg.
`timescale 1ns / 1ps
module cc2d_back #(
   parameter int MAX_IMAGE_DIM  = cc2d_pkg::MAX_IMAGE_DIM_DEF,
   parameter int MAX_FILTER_DIM = cc2d_pkg::MAX_FILTER_DIM_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   input  cc2d_pkg::cmd_type cmd,
   input  logic [6:0]        image_rows,
   input  logic [6:0]        image_cols,
   input  logic [3:0]        filter_rows,
   input  logic [3:0]        filter_cols,
   input  logic              edge_mode,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [39:0]       rsp_tdata
);
   localparam int AW    = $clog2(MAX_IMAGE_DIM);
   localparam int DEPTH = 1 << (2 * AW);
   localparam int FW    = (MAX_FILTER_DIM > 1) ? $clog2(MAX_FILTER_DIM) : 1;
   localparam int TDEPTH = 1 << (2 * FW);
   localparam int DIM_W = $clog2(MAX_IMAGE_DIM + 1);
   localparam int FD_W  = $clog2(MAX_FILTER_DIM + 1);

   typedef enum logic [2:0] {
      ST_CLR, ST_IDLE, ST_TAP, ST_RD, ST_MAC, ST_WB, ST_OUT
   } state_type;

   state_type state_ff;
   logic signed [31:0] acc_mem [DEPTH];
   logic signed [15:0] tap_mem [TDEPTH];
   logic [2*AW-1:0]    clr_cnt_ff;
   logic [FD_W-1:0]    j_ff, i_ff;
   logic [2*AW-1:0]    addr_ff;
   logic signed [31:0] acc_rd_ff;
   logic signed [15:0] tap_rd_ff;
   logic signed [31:0] prod_ff;
   logic               ovf_ff;
   logic [31:0]        rd_val_ff;
   logic               rsp_valid_ff;
   logic [31:0]        rsp_rd_ff;
   logic               rsp_ovf_ff;
   logic               rsp_load;
   cc2d_pkg::cmd_type  cur_ff;
   logic [DIM_W-1:0]   ir, ic;
   logic [FD_W-1:0]    fr, fc;
   logic signed [AW+2:0] pr, pc, yr, xc;
   logic                 okr, okc;
   logic signed [32:0]   sum;
   logic signed [31:0]   sat;
   logic                 sat_hit;

   function automatic logic [FD_W-1:0] clampf(input logic [3:0] v,
                                              input logic [DIM_W-1:0] lim);
      logic [FD_W-1:0] d;
      begin
         d = (v == 4'd0) ? FD_W'(1) :
             (32'(v) > 32'(MAX_FILTER_DIM)) ? FD_W'(MAX_FILTER_DIM) : FD_W'(v);
         if (32'(d) > 32'(lim)) d = FD_W'(lim);
         return d;
      end
   endfunction

   // Effective sizes after clamping.
   always_comb begin
      ir = (image_rows == 7'd0) ? DIM_W'(1) :
           (32'(image_rows) > 32'(MAX_IMAGE_DIM)) ? DIM_W'(MAX_IMAGE_DIM) :
           DIM_W'(image_rows);
      ic = (image_cols == 7'd0) ? DIM_W'(1) :
           (32'(image_cols) > 32'(MAX_IMAGE_DIM)) ? DIM_W'(MAX_IMAGE_DIM) :
           DIM_W'(image_cols);
      fr = clampf(filter_rows, ir);
      fc = clampf(filter_cols, ic);
   end

   // Target position of the current tap, with wrap or drop at the edges.
   always_comb begin
      pr = (AW+3)'(cur_ff.row) + (AW+3)'(j_ff) - (AW+3)'(fr >> 1);
      pc = (AW+3)'(cur_ff.col) + (AW+3)'(i_ff) - (AW+3)'(fc >> 1);
      yr = pr;
      xc = pc;
      if (pr < 0) yr = pr + (AW+3)'(ir);
      else if (pr >= (AW+3)'(ir)) yr = pr - (AW+3)'(ir);
      if (pc < 0) xc = pc + (AW+3)'(ic);
      else if (pc >= (AW+3)'(ic)) xc = pc - (AW+3)'(ic);
      okr = (pr >= 0 && pr < (AW+3)'(ir)) ||
            (!edge_mode && yr >= 0 && yr < (AW+3)'(ir));
      okc = (pc >= 0 && pc < (AW+3)'(ic)) ||
            (!edge_mode && xc >= 0 && xc < (AW+3)'(ic));
   end

   // Saturating accumulate of the registered product.
   always_comb begin
      sum = 33'(acc_rd_ff) + 33'(prod_ff);
      sat_hit = (sum[32] != sum[31]);
      sat = sat_hit ? (sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff) : sum[31:0];
   end

   // The output register takes a finished word when it is empty or being drained.
   assign rsp_load   = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_tready);
   assign cmd_ready  = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_ovf_ff, rsp_rd_ff};

   // Sequencer: each tap goes through read, multiply and write-back steps; a dropped tap skips the multiply.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         cur_ff       <= '0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
            rsp_rd_ff    <= rd_val_ff;
            rsp_ovf_ff   <= ovf_ff;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_CLR: begin
               acc_mem[clr_cnt_ff] <= '0;
               clr_cnt_ff <= clr_cnt_ff + 1'b1;
               if (clr_cnt_ff == '1)
                  state_ff <= (cur_ff.kind == cc2d_pkg::KIND_CLEAR) ? ST_OUT : ST_IDLE;
            end
            ST_IDLE: begin
               if (cmd_valid) begin
                  cur_ff    <= cmd;
                  ovf_ff    <= 1'b0;
                  rd_val_ff <= '0;
                  j_ff      <= fr - 1'b1;
                  i_ff      <= fc - 1'b1;
                  unique case (cmd.kind)
                     cc2d_pkg::KIND_TAP: begin
                        if (32'(cmd.row) < 32'(MAX_FILTER_DIM) &&
                            32'(cmd.col) < 32'(MAX_FILTER_DIM))
                           tap_mem[{FW'(cmd.row), FW'(cmd.col)}] <= cmd.value;
                        state_ff <= ST_OUT;
                     end
                     cc2d_pkg::KIND_IMP:
                        state_ff <= cmd.in_image ? ST_RD : ST_OUT;
                     cc2d_pkg::KIND_READ: begin
                        if (cmd.in_image)
                           rd_val_ff <= acc_mem[{AW'(cmd.row), AW'(cmd.col)}];
                        state_ff <= ST_OUT;
                     end
                     default: state_ff <= ST_CLR;
                  endcase
               end
            end
            ST_RD: begin
               addr_ff   <= {yr[AW-1:0], xc[AW-1:0]};
               acc_rd_ff <= acc_mem[{yr[AW-1:0], xc[AW-1:0]}];
               tap_rd_ff <= tap_mem[{j_ff[FW-1:0], i_ff[FW-1:0]}];
               state_ff  <= (okr && okc) ? ST_MAC : ST_WB;
               prod_ff   <= '0;
            end
            ST_MAC: begin
               prod_ff  <= 32'(tap_rd_ff) * 32'($signed(cur_ff.value));
               state_ff <= ST_WB;
            end
            ST_WB: begin
               if (okr && okc) begin
                  acc_mem[addr_ff] <= sat;
                  if (sat_hit) ovf_ff <= 1'b1;
               end
               if (i_ff != '0) begin
                  i_ff     <= i_ff - 1'b1;
                  state_ff <= ST_RD;
               end else if (j_ff != '0) begin
                  i_ff     <= fc - 1'b1;
                  j_ff     <= j_ff - 1'b1;
                  state_ff <= ST_RD;
               end else begin
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (rsp_load) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule
